@@ rtl/alm_pkg.sv @@
`default_nettype none
package alm_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 24;

  typedef struct packed {
    logic [2:0]                   channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                         block_end;
  } alm_in_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [22:0] peak;
    logic [22:0] rms;
    logic [22:0] noise_floor;
  } alm_out_t;

  localparam logic [1:0] REG_RMS_COEFF  = 2'd0;
  localparam logic [1:0] REG_PEAK_DECAY = 2'd1;
  localparam logic [1:0] REG_FLOOR_RISE = 2'd2;
  localparam logic [1:0] REG_ACTIVE     = 2'd3;

  localparam logic [23:0] FLOOR_RESET = 24'hFFFFFF;
  localparam logic [22:0] Q23_MAX     = 23'h7FFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_MS,
    ST_DIV,
    ST_SQRT,
    ST_PEAK,
    ST_FLOOR,
    ST_WRITE,
    ST_OUT
  } alm_state_t;

endpackage
`default_nettype wire

@@ rtl/audio_level_meter_top.sv @@
`default_nettype none
// Per-channel peak, RMS and noise-floor meter. Each request carries one signed
// sample, its channel and an end-of-block flag; samples of channels at or above
// active_channels are dropped at once. A sample without block_end passes through
// acceptance, the 32-bit serial squarer, the 32-bit serial smoothing multiply and
// the state write-back before the next request can be accepted. A sample with
// block_end adds a square root, a peak-decay multiply, a floor-rise multiply
// (skipped when the RMS falls below the floor) and an output state; the
// channel's first block adds a division before the square root.
// One request is handled at a time. A result waits in the output register while
// further requests are accepted, but a block_end request is held off until the
// waiting result has been taken, and the output cycle stalls until it is.
module audio_level_meter_top
  import alm_pkg::*;
#(
  parameter int COUNT_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire alm_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output alm_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int SB  = SAMPLE_BITS;
  localparam int CHB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FRAC = 2 * (SB - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [61:0] SUM_MAX = {62{1'b1}};

  // Configuration.
  logic [15:0] rms_coeff_r, peak_decay_r, floor_rise_r;
  logic [3:0]  active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_coeff_r  <= 16'd64;
      peak_decay_r <= 16'd65000;
      floor_rise_r <= 16'd8;
      active_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RMS_COEFF:  rms_coeff_r  <= cfg_data;
        REG_PEAK_DECAY: peak_decay_r <= cfg_data;
        REG_FLOOR_RISE: floor_rise_r <= cfg_data;
        REG_ACTIVE:     active_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Channel state.
  logic [31:0]           ms_r    [CHANNELS];
  logic [23:0]           bpk_r   [CHANNELS];
  logic [61:0]           sum_r   [CHANNELS];
  logic [COUNT_BITS-1:0] cnt_r   [CHANNELS];
  logic [23:0]           phold_r [CHANNELS];
  logic [23:0]           fl_r    [CHANNELS];
  logic [CHANNELS-1:0]   warm_r;

  alm_state_t st_r, st_nxt;
  logic [CHB-1:0]   ch_r;
  logic [2:0]       chtag_r;
  logic             last_r;
  logic [SB-1:0]    mag_r;
  logic [31:0]      x2_r, ms_w_r;
  logic [61:0]      sum_w_r;
  logic [COUNT_BITS-1:0] cnt_w_r;
  logic [23:0]      bpk_w_r;
  logic [22:0]      rms_w_r, pk_w_r, fl_w_r;
  logic             msdir_r;
  logic             sub_go_r;
  alm_out_t         out_r;
  logic             outv_r;

  // Serial units; the multiplier is shared by all multiply states.
  logic             mul_start;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic             mul_done;
  logic [63:0]      mul_p;
  logic             div_done, sqrt_done;
  logic [61:0]      div_q;
  logic [22:0]      sqrt_root;
  logic [COUNT_BITS-1:0] den;

  alm_serial_mul #(.AW(32), .BW(32)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  assign den = (cnt_w_r == '0) ? COUNT_BITS'(1) : cnt_w_r;

  alm_serial_div #(.NW(62), .DW(COUNT_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(sub_go_r && st_r == ST_DIV),
    .num(sum_w_r), .den(den), .done(div_done), .quo(div_q)
  );

  alm_serial_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sub_go_r && st_r == ST_SQRT),
    .rad({ms_w_r, 14'd0}), .done(sqrt_done), .root(sqrt_root)
  );

  logic [4:0] lim;
  logic       in_act;
  logic [SB-1:0] raw, mag;
  assign lim    = (active_r > 4'(CHANNELS)) ? 5'(CHANNELS) : {1'b0, active_r};
  assign in_act = {2'b0, in_data.channel} < lim;
  assign in_ready = (st_r == ST_IDLE) && !(outv_r && !out_ready && in_data.block_end);
  assign raw = SB'(in_data.sample);
  assign mag = raw[SB-1] ? (~raw + 1'b1) : raw;

  // Saturation helpers on registered products.
  logic [63:0] x2_full;
  logic [31:0] x2_sat;
  logic [23:0] mag23;
  logic [22:0] mag23_sat;
  logic [31:0] msdiff, x2_m;
  logic [47:0] ms_step;
  logic [23:0] pk_dec;
  logic [22:0] fl_cur;
  logic [23:0] fl_rise;
  always_comb begin
    if (FRAC >= 32) x2_full = mul_p >> (FRAC - 32);
    else            x2_full = mul_p << (32 - FRAC);
    x2_sat = (x2_full[63:32] != '0) ? 32'hFFFFFFFF : x2_full[31:0];
    if (SB >= 24) mag23 = 24'(mag_r >> (SB - 24));
    else          mag23 = 24'(mag_r) << (24 - SB);
    mag23_sat = mag23[23] ? Q23_MAX : mag23[22:0];
    x2_m     = x2_r;
    msdiff   = msdir_r ? (x2_m - ms_w_r) : (ms_w_r - x2_m);
    ms_step  = mul_p[63:16] ;
    pk_dec   = mul_p[39:16];
    fl_cur   = fl_w_r;
    fl_rise  = mul_p[39:16];
  end

  logic [CHB-1:0] in_ch;
  assign in_ch = CHB'(in_data.channel);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_valid && in_ready && in_act) st_nxt = ST_SQ;
      ST_SQ:    if (mul_done) st_nxt = ST_MS;
      ST_MS:    if (mul_done) st_nxt = !last_r ? ST_WRITE :
                                (warm_r[ch_r] ? ST_SQRT : ST_DIV);
      ST_DIV:   if (div_done) st_nxt = ST_SQRT;
      ST_SQRT:  if (sqrt_done) st_nxt = ST_PEAK;
      ST_PEAK:  if (mul_done) st_nxt = ST_FLOOR;
      ST_FLOOR: if (mul_done || (sub_go_r && rms_w_r < fl_w_r)) st_nxt = ST_WRITE;
      ST_WRITE: st_nxt = last_r ? ST_OUT : ST_IDLE;
      ST_OUT:   if (!outv_r || out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (st_r)
      ST_SQ: begin
        mul_start = sub_go_r;
        mul_a = 32'(mag_r);
        mul_b = 32'(mag_r);
      end
      ST_MS: begin
        mul_start = sub_go_r;
        mul_a = msdiff;
        mul_b = {16'd0, rms_coeff_r};
      end
      ST_PEAK: begin
        mul_start = sub_go_r;
        mul_a = {8'd0, phold_r[ch_r]};
        mul_b = {16'd0, peak_decay_r};
      end
      ST_FLOOR: begin
        mul_start = sub_go_r && !(rms_w_r < fl_w_r);
        mul_a = {9'd0, rms_w_r - fl_cur};
        mul_b = {16'd0, floor_rise_r};
      end
      default: ;
    endcase
  end

  logic [62:0] sum_add;
  assign sum_add = {1'b0, sum_w_r} + {31'd0, x2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      sub_go_r <= 1'b0;
      outv_r   <= 1'b0;
      warm_r   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        ms_r[i]    <= '0;
        bpk_r[i]   <= '0;
        sum_r[i]   <= '0;
        cnt_r[i]   <= '0;
        phold_r[i] <= '0;
        fl_r[i]    <= FLOOR_RESET;
      end
    end else begin
      st_r     <= st_nxt;
      sub_go_r <= (st_nxt != st_r);
      if (st_r == ST_OUT && (!outv_r || out_ready)) begin
        outv_r <= 1'b1;
        out_r  <= '{out_channel: chtag_r, peak: pk_w_r, rms: rms_w_r,
                    noise_floor: fl_w_r};
      end else if (outv_r && out_ready) begin
        outv_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: if (in_valid && in_ready && in_act) begin
          ch_r    <= in_ch;
          chtag_r <= in_data.channel;
          last_r  <= in_data.block_end;
          mag_r   <= mag;
          ms_w_r  <= ms_r[in_ch];
          sum_w_r <= sum_r[in_ch];
          cnt_w_r <= cnt_r[in_ch];
          bpk_w_r <= bpk_r[in_ch];
          fl_w_r  <= (fl_r[in_ch][23]) ? Q23_MAX : fl_r[in_ch][22:0];
        end
        ST_SQ: if (mul_done) begin
          x2_r    <= x2_sat;
          msdir_r <= x2_sat >= ms_w_r;
          if ({1'b0, mag23_sat} > bpk_w_r) bpk_w_r <= {1'b0, mag23_sat};
          if (cnt_w_r != COUNT_MAX) cnt_w_r <= cnt_w_r + 1'b1;
        end
        ST_MS: if (mul_done) begin
          ms_w_r  <= msdir_r ? ms_w_r + ms_step[31:0] : ms_w_r - ms_step[31:0];
          sum_w_r <= sum_add[62] ? SUM_MAX : sum_add[61:0];
        end
        ST_DIV: if (div_done) begin
          ms_w_r <= (div_q[61:32] != '0) ? 32'hFFFFFFFF : div_q[31:0];
          warm_r[ch_r] <= 1'b1;
        end
        ST_SQRT: if (sqrt_done) rms_w_r <= sqrt_root;
        ST_PEAK: if (mul_done)
          pk_w_r <= (bpk_w_r > pk_dec) ? bpk_w_r[22:0] : pk_dec[22:0];
        ST_FLOOR: begin
          if (sub_go_r && rms_w_r < fl_w_r) fl_w_r <= rms_w_r;
          else if (mul_done) fl_w_r <= fl_w_r + fl_rise[22:0];
        end
        ST_WRITE: begin
          ms_r[ch_r] <= ms_w_r;
          if (last_r) begin
            bpk_r[ch_r]   <= '0;
            sum_r[ch_r]   <= '0;
            cnt_r[ch_r]   <= '0;
            phold_r[ch_r] <= {1'b0, pk_w_r};
            fl_r[ch_r]    <= {1'b0, fl_w_r};
          end else begin
            bpk_r[ch_r] <= bpk_w_r;
            sum_r[ch_r] <= sum_w_r;
            cnt_r[ch_r] <= cnt_w_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = outv_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

@@ rtl/alm_serial_mul.sv @@
`default_nettype none
// Shift-and-add multiplier: one bit of b per cycle, product = a * b.
module alm_serial_mul
  import alm_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [AW-1:0]   a,
  input  wire logic [BW-1:0]   b,
  output logic                 done,
  output logic [AW+BW-1:0]     prod
);
  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] a_r, a_nxt;
  logic [BW-1:0]    b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = {{BW{1'b0}}, a};
      b_nxt    = b;
      cnt_nxt  = CW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[0]) acc_nxt = acc_r + a_r;
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ rtl/alm_serial_div.sv @@
`default_nettype none
// Restoring divider: one quotient bit per cycle.
module alm_serial_div
  import alm_pkg::*;
#(
  parameter int NW = 62,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW:0]   trial;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule
`default_nettype wire

@@ rtl/alm_serial_sqrt.sv @@
`default_nettype none
// Digit-by-digit square root of a 46-bit value, one result bit per cycle.
module alm_serial_sqrt
  import alm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [45:0] rad,
  output logic             done,
  output logic [22:0]      root
);
  logic [45:0] v_r, v_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [22:0] q_r, q_nxt;
  logic [24:0] trial, t2;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[22:0], v_r[45:44]};
    t2       = {q_r, 2'b01};
    if (start) begin
      v_nxt    = rad;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = 5'd23;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt = v_r << 2;
      if (trial >= t2) begin
        rem_nxt = trial - t2;
        q_nxt   = {q_r[21:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[21:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r   <= v_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign root = q_r;
endmodule
`default_nettype wire
